// ----- hdl/eoe_pkg.sv -----
// ============================================================================
// eoe_pkg: shared types, constants and functions of the ease-out elastic curve
// Holds the default configuration, the CORDIC angle table, the square-root
// helper for the power-of-two roots and the saturation function.
// ============================================================================
package eoe_pkg;

    // Default configuration of the curve.
    localparam int SINE_TABLE_DEPTH_DEF = 1024;
    localparam int EXP_TABLE_DEPTH_DEF  = 256;
    localparam int FRACTION_BITS_DEF    = 16;

    // CORDIC rotation settings.
    localparam int CORDIC_STEPS = 30;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // Power-of-two multiplier chain length (one stage per fraction bit).
    localparam int EXP_STEPS = 16;

    // Latencies of the pipeline sections in cycles.
    localparam int SINE_LATENCY = CORDIC_STEPS + 4;
    localparam int EXP_LATENCY  = EXP_STEPS + 2;
    localparam int MIX_LATENCY  = 4;

    // Reciprocal of three for the angle scaling, valid for 20-bit dividends.
    localparam logic [20:0] RECIP_THREE = 21'd1398102;

    // Arc tangent of 2^-i in units of 2^32 per turn.
    localparam logic [29:0] TURN_ATAN [CORDIC_STEPS] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
        30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1
    };

    // Items that travel beside the curve computation.
    typedef struct packed {
        logic               zero;
        logic               full;
        logic signed [31:0] start;
        logic signed [31:0] change;
    } side_t;

    // Integer square root, evaluated at elaboration time only.
    function automatic logic [63:0] isqrt64(input logic [63:0] num);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bitv;
        n    = num;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (bitv > n) begin
                bitv = bitv >> 2;
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (bitv != 64'd0) begin
                if (n >= res + bitv) begin
                    n   = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // Root 2^30 * 2^-(2^-k) for the k-th multiplier stage.
    function automatic logic [29:0] exp_root(input int k);
        logic [63:0] r;
        r = isqrt64(64'd1 << 59);
        for (int j = 1; j < k; j++) begin
            r = isqrt64(r << 30);
        end
        return r[29:0];
    endfunction

    // Saturate a wide sum to the signed 32-bit range.
    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -35'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// ----- hdl/eoe_div.sv -----
// ============================================================================
// eoe_div: pipelined restoring divider for the time fraction
// Produces floor(elapsed * 2^F / duration) for elapsed below duration,
// one quotient bit per stage.
// ============================================================================
module eoe_div #(
    parameter int FRAC_BITS = eoe_pkg::FRACTION_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [15:0]          el_in,
    input  logic [15:0]          du_in,
    output logic [FRAC_BITS-1:0] xq_out
);
    import eoe_pkg::*;

    logic [15:0]          rem_reg [FRAC_BITS];
    logic [15:0]          du_reg  [FRAC_BITS];
    logic [FRAC_BITS-1:0] quo_reg [FRAC_BITS];

    genvar j;
    generate
        for (j = 0; j < FRAC_BITS; j++) begin : g_stage
            logic [15:0]          rem_prev;
            logic [15:0]          du_prev;
            logic [FRAC_BITS-1:0] quo_prev;
            logic [16:0]          rem_dbl;
            logic                 ge;
            logic [15:0]          rem_next;
            logic [FRAC_BITS-1:0] quo_next;

            if (j == 0) begin : g_first
                assign rem_prev = el_in;
                assign du_prev  = du_in;
                assign quo_prev = '0;
            end else begin : g_rest
                assign rem_prev = rem_reg[j-1];
                assign du_prev  = du_reg[j-1];
                assign quo_prev = quo_reg[j-1];
            end

            // Shift the partial remainder and try one subtraction.
            always_comb begin
                rem_dbl  = {rem_prev, 1'b0};
                ge       = (rem_dbl >= {1'b0, du_prev});
                rem_next = ge ? 16'(rem_dbl - {1'b0, du_prev}) : rem_dbl[15:0];
                quo_next = {quo_prev[FRAC_BITS-2:0], ge};
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j] <= rem_next;
                    du_reg[j]  <= du_prev;
                    quo_reg[j] <= quo_next;
                end
            end
        end
    endgenerate

    assign xq_out = quo_reg[FRAC_BITS-1];

endmodule

// ----- hdl/eoe_sine.sv -----
// ============================================================================
// eoe_sine: angle scaling and pipelined CORDIC sine
// Turns the time fraction into the oscillation angle, truncates it to the
// sine sample grid and rotates one CORDIC step per stage to a Q1.15 sine.
// ============================================================================
module eoe_sine #(
    parameter int FRAC_BITS  = eoe_pkg::FRACTION_BITS_DEF,
    parameter int SINE_DEPTH = eoe_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [FRAC_BITS-1:0]     xq_in,
    output logic signed [16:0]       sine_out
);
    import eoe_pkg::*;

    localparam int SINE_LOG = $clog2(SINE_DEPTH);
    localparam logic [15:0] ANGLE_MASK = ~16'((32'd1 << (16 - SINE_LOG)) - 32'd1);

    // Stage 1: scale by ten and bring to 16 fraction bits.
    logic [FRAC_BITS+3:0]  ten_x;
    logic [FRAC_BITS+19:0] scaled;
    logic [19:0]           w_next;
    logic                  low_next;
    logic [19:0]           w_reg;
    logic                  low_reg;

    always_comb begin
        ten_x    = (FRAC_BITS+4)'(xq_in) * (FRAC_BITS+4)'(10);
        scaled   = {ten_x, 16'b0};
        w_next   = scaled[FRAC_BITS+19:FRAC_BITS];
        low_next = |scaled[FRAC_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w_reg   <= w_next;
            low_reg <= low_next;
        end
    end

    // Stage 2: divide by three through the reciprocal.
    logic [40:0] recip_prod;
    logic [18:0] q_next;
    logic [18:0] q_reg;
    logic [19:0] w2_reg;
    logic        low2_reg;

    always_comb begin
        recip_prod = 41'(w_reg) * 41'(RECIP_THREE);
        q_next     = recip_prod[40:22];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg    <= q_next;
            w2_reg   <= w_reg;
            low2_reg <= low_reg;
        end
    end

    // Stage 3: quarter-turn offset truncated toward zero, then fold to +-1/4 turn.
    logic [19:0]        three_q;
    logic               inexact;
    logic [15:0]        angle;
    logic [15:0]        angle_grid;
    logic signed [32:0] turn;
    logic signed [33:0] z0_next;
    logic signed [33:0] z0_reg;

    always_comb begin
        three_q    = {q_reg, 1'b0} + {1'b0, q_reg};
        inexact    = low2_reg || (three_q != w2_reg);
        angle      = q_reg[15:0] - 16'd16384
                     + 16'((q_reg < 19'd16384) && inexact);
        angle_grid = angle & ANGLE_MASK;
        turn       = $signed({angle_grid[15], angle_grid, 16'b0});
        if (turn > 33'sd1073741824) begin
            z0_next = 34'sd2147483648 - 34'(turn);
        end else if (turn < -33'sd1073741824) begin
            z0_next = -34'sd2147483648 - 34'(turn);
        end else begin
            z0_next = 34'(turn);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z0_reg <= z0_next;
        end
    end

    // CORDIC rotation, one step per stage.
    logic signed [33:0] x_reg [CORDIC_STEPS];
    logic signed [33:0] y_reg [CORDIC_STEPS];
    logic signed [33:0] z_reg [CORDIC_STEPS];

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++) begin : g_rot
            logic signed [33:0] x_prev;
            logic signed [33:0] y_prev;
            logic signed [33:0] z_prev;
            logic signed [33:0] dx;
            logic signed [33:0] dy;
            logic signed [33:0] x_next;
            logic signed [33:0] y_next;
            logic signed [33:0] z_next;

            if (i == 0) begin : g_first
                assign x_prev = CORDIC_GAIN;
                assign y_prev = '0;
                assign z_prev = z0_reg;
            end else begin : g_rest
                assign x_prev = x_reg[i-1];
                assign y_prev = y_reg[i-1];
                assign z_prev = z_reg[i-1];
            end

            always_comb begin
                dx = y_prev >>> i;
                dy = x_prev >>> i;
                if (z_prev >= 0) begin
                    x_next = x_prev - dx;
                    y_next = y_prev + dy;
                    z_next = z_prev - $signed({4'b0, TURN_ATAN[i]});
                end else begin
                    x_next = x_prev + dx;
                    y_next = y_prev - dy;
                    z_next = z_prev + $signed({4'b0, TURN_ATAN[i]});
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    x_reg[i] <= x_next;
                    y_reg[i] <= y_next;
                    z_reg[i] <= z_next;
                end
            end
        end
    endgenerate

    // Final stage: round to Q1.15 and clamp.
    logic signed [33:0] y_round;
    logic signed [18:0] y_q15;
    logic signed [16:0] sine_next;
    logic signed [16:0] sine_reg;

    always_comb begin
        y_round = y_reg[CORDIC_STEPS-1] + 34'sd16384;
        y_q15   = 19'(y_round >>> 15);
        if (y_q15 > 19'sd32768) begin
            sine_next = 17'sd32768;
        end else if (y_q15 < -19'sd32768) begin
            sine_next = -17'sd32768;
        end else begin
            sine_next = y_q15[16:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sine_reg <= sine_next;
        end
    end

    assign sine_out = sine_reg;

endmodule

// ----- hdl/eoe_exp.sv -----
// ============================================================================
// eoe_exp: pipelined power-of-two decay 2^(-10x)
// Samples the exponent on the table grid and multiplies 2^30 by one root of
// two per set fraction bit, one multiplier per stage, then shifts and rounds.
// ============================================================================
module eoe_exp #(
    parameter int FRAC_BITS = eoe_pkg::FRACTION_BITS_DEF,
    parameter int EXP_DEPTH = eoe_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [FRAC_BITS-1:0] xq_in,
    output logic [16:0]          exp_out
);
    import eoe_pkg::*;

    localparam int EXP_LOG = $clog2(EXP_DEPTH);

    // Stage 1: exponent 10 * i / depth in Q16.
    logic [EXP_LOG-1:0] idx;
    logic [19:0]        e_next;
    logic [3:0]         n_reg [EXP_STEPS+1];
    logic [15:0]        f_reg [EXP_STEPS+1];
    logic [30:0]        p_reg [EXP_STEPS+1];

    always_comb begin
        idx    = xq_in[FRAC_BITS-1 -: EXP_LOG];
        e_next = 20'({(EXP_LOG+4)'(idx) * (EXP_LOG+4)'(10), {(16-EXP_LOG){1'b0}}});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg[0] <= e_next[19:16];
            f_reg[0] <= e_next[15:0];
            p_reg[0] <= 31'd1 << 30;
        end
    end

    // Root multiplier chain, one fraction bit per stage.
    genvar k;
    generate
        for (k = 1; k <= EXP_STEPS; k++) begin : g_mul
            localparam logic [29:0] ROOT = exp_root(k);
            logic [60:0] prod;
            logic [30:0] p_next;

            always_comb begin
                prod   = 61'(p_reg[k-1]) * 61'(ROOT);
                p_next = f_reg[k-1][EXP_STEPS-k] ? prod[60:30] : p_reg[k-1];
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    p_reg[k] <= p_next;
                    n_reg[k] <= n_reg[k-1];
                    f_reg[k] <= f_reg[k-1];
                end
            end
        end
    endgenerate

    // Last stage: integer part as a shift, then round to Q1.16.
    logic [30:0] p_shift;
    logic [30:0] p_round;
    logic [16:0] exp_reg;

    always_comb begin
        p_shift = p_reg[EXP_STEPS] >> n_reg[EXP_STEPS];
        p_round = p_shift + 31'd8192;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            exp_reg <= p_round[30:14];
        end
    end

    assign exp_out = exp_reg;

endmodule

// ----- hdl/eoe_mix.sv -----
// ============================================================================
// eoe_mix: scaling, offset and saturation of the eased value
// Multiplies sine by decay, scales the change amount in two partial products,
// adds start and change and selects the endpoint cases.
// ============================================================================
module eoe_mix (
    input  logic                aclk,
    input  logic                en,
    input  eoe_pkg::side_t      side_in,
    input  logic signed [16:0]  sine_in,
    input  logic [16:0]         exp_in,
    output logic [31:0]         eased_out
);
    import eoe_pkg::*;

    side_t side_reg [3];

    // Stage 1: sine times decay.
    logic signed [34:0] m_full;
    logic signed [32:0] m_reg;

    always_comb begin
        m_full = 35'(sine_in) * 35'($signed({1'b0, exp_in}));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg       <= m_full[32:0];
            side_reg[0] <= side_in;
        end
    end

    // Stage 2: change times the low and high halves of the factor.
    logic signed [48:0] plo_next;
    logic signed [48:0] phi_next;
    logic signed [48:0] plo_reg;
    logic signed [48:0] phi_reg;

    always_comb begin
        plo_next = 49'(side_reg[0].change) * 49'($signed({1'b0, m_reg[15:0]}));
        phi_next = 49'(side_reg[0].change) * 49'($signed(m_reg[32:16]));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            plo_reg     <= plo_next;
            phi_reg     <= phi_next;
            side_reg[1] <= side_reg[0];
        end
    end

    // Stage 3: combine the partial products and scale down by 2^31.
    logic signed [65:0] full_prod;
    logic signed [33:0] prod_reg;

    always_comb begin
        full_prod = (66'(phi_reg) <<< 16) + 66'(plo_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg    <= full_prod[64:31];
            side_reg[2] <= side_reg[1];
        end
    end

    // Stage 4: offsets, saturation and endpoint selection.
    logic signed [34:0] bc_sum;
    logic signed [34:0] total;
    logic [31:0]        eased_next;
    logic [31:0]        eased_reg;

    always_comb begin
        bc_sum = 35'(side_reg[2].start) + 35'(side_reg[2].change);
        total  = bc_sum + 35'(prod_reg);
        priority if (side_reg[2].zero) begin
            eased_next = side_reg[2].start;
        end else if (side_reg[2].full) begin
            eased_next = sat32(bc_sum);
        end else begin
            eased_next = sat32(total);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            eased_reg <= eased_next;
        end
    end

    assign eased_out = eased_reg;

endmodule

// ----- hdl/ease_out_elastic_curve.sv -----
// ============================================================================
// ease_out_elastic_curve: pipelined ease-out elastic tween evaluator
//
//   Channel  Direction  Payload
//   s_       in         tdata[95:0]: elapsed, duration, start_value, change_amount
//   m_       out        tdata[31:0]: eased_value
//
// One transfer is accepted every cycle unless the pipeline holds; each item
// passes through the divider, the CORDIC sine and the output arithmetic.
// The CORDIC chain of one stage per rotation step sets the latency.
// The whole pipeline advances together; it holds when the output is full and
// not taken, and s_tready follows that hold.
// Reset (aresetn low, synchronous) clears the valid bits only.
// ============================================================================
module ease_out_elastic_curve #(
    parameter int SINE_TABLE_DEPTH = eoe_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int EXP_TABLE_DEPTH  = eoe_pkg::EXP_TABLE_DEPTH_DEF,
    parameter int FRACTION_BITS    = eoe_pkg::FRACTION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // elapsed[15:0], duration[31:16], start_value[63:32], change_amount[95:64]
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // eased_value[31:0]
    output logic [31:0] m_tdata
);
    import eoe_pkg::*;

    localparam int SIDE_DELAY = FRACTION_BITS + SINE_LATENCY;
    localparam int TOTAL_LAT  = SIDE_DELAY + MIX_LATENCY;
    localparam int EXP_PAD    = SINE_LATENCY - EXP_LATENCY;

    logic en;
    logic [TOTAL_LAT-1:0] valid_reg;

    // Pipeline moves when the output stage is empty or being taken.
    assign en       = !valid_reg[TOTAL_LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = valid_reg[TOTAL_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[TOTAL_LAT-2:0], s_tvalid};
        end
    end

    // Endpoint flags and the divider operand.
    logic [15:0] el;
    logic [15:0] du;
    side_t       side_in;
    logic [15:0] el_div;

    always_comb begin
        el             = s_tdata[15:0];
        du             = s_tdata[31:16];
        side_in.zero   = (el == 16'd0);
        side_in.full   = (el >= du);
        side_in.start  = s_tdata[63:32];
        side_in.change = s_tdata[95:64];
        el_div         = side_in.full ? 16'd0 : el;
    end

    // Side items wait for the curve factors.
    side_t side_reg [SIDE_DELAY];

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            for (int d = 1; d < SIDE_DELAY; d++) begin
                side_reg[d] <= side_reg[d-1];
            end
        end
    end

    logic [FRACTION_BITS-1:0] xq;
    logic signed [16:0]       sine_s;
    logic [16:0]              exp_e;

    eoe_div #(
        .FRAC_BITS (FRACTION_BITS)
    ) u_div (
        .aclk   (aclk),
        .en     (en),
        .el_in  (el_div),
        .du_in  (du),
        .xq_out (xq)
    );

    eoe_sine #(
        .FRAC_BITS  (FRACTION_BITS),
        .SINE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sine (
        .aclk     (aclk),
        .en       (en),
        .xq_in    (xq),
        .sine_out (sine_s)
    );

    eoe_exp #(
        .FRAC_BITS (FRACTION_BITS),
        .EXP_DEPTH (EXP_TABLE_DEPTH)
    ) u_exp (
        .aclk    (aclk),
        .en      (en),
        .xq_in   (xq),
        .exp_out (exp_e)
    );

    // Align the shorter decay path with the sine path.
    logic [16:0] exp_pad_reg [EXP_PAD];

    always_ff @(posedge aclk) begin
        if (en) begin
            exp_pad_reg[0] <= exp_e;
            for (int d = 1; d < EXP_PAD; d++) begin
                exp_pad_reg[d] <= exp_pad_reg[d-1];
            end
        end
    end

    eoe_mix u_mix (
        .aclk      (aclk),
        .en        (en),
        .side_in   (side_reg[SIDE_DELAY-1]),
        .sine_in   (sine_s),
        .exp_in    (exp_pad_reg[EXP_PAD-1]),
        .eased_out (m_tdata)
    );

    // The sine of a valid item stays within one in Q1.15.
    a_sine_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[SIDE_DELAY-1] |-> (sine_s <= 17'sd32768) && (sine_s >= -17'sd32768))
        else $error("sine factor out of range");

    // The aligned decay factor of a valid item never exceeds one in Q1.16.
    a_exp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[SIDE_DELAY-1] |-> (exp_pad_reg[EXP_PAD-1] <= 17'd65536))
        else $error("decay factor out of range");

    // Reset empties the pipeline, so no result follows it directly.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule
